[sv/vlcbr_pkg.sv]
package vlcbr_pkg;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_UNARY   = 3'd1,
		OP_BOUNDED = 3'd2,
		OP_MINBIN  = 3'd3,
		OP_GAMMA   = 3'd4,
		OP_DELTA   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_RANGE = 2'd3
	} st_t;

	// classified item, as held in the queue
	typedef struct packed {
		op_t         op;
		logic [31:0] word;
		logic [5:0]  nbits;     // push length in bits, 0..32
		logic [63:0] lo;
		logic        range_err; // hi <= lo
		logic [6:0]  m_clip;    // hi-lo-1, saturated at 127
		logic        m_big;     // hi-lo-1 over the run limit
		logic [63:0] hm1;       // hi-1 = lo + (hi-lo-1)
		logic [6:0]  mb_b;      // bit length of hi-lo-1
		logic        mb_big;    // mb_b-1 over the run limit
		logic [63:0] mb_t;      // 2^mb_b - (hi-lo), short-code count
		logic [63:0] lo_mt;     // lo - mb_t
	} item_t;

	// leading zeros of a 64-bit word, 64 when all zero
	function automatic logic [6:0] clz64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(63 - i);
			end
		end
		return n;
	endfunction

endpackage

[sv/vlcbr_front.sv]
module vlcbr_front import vlcbr_pkg::*; #(
	parameter int MAX_RUN = 63
) (
	input  logic [2:0]  opcode,
	input  logic [31:0] word,
	input  logic [2:0]  word_bytes,
	input  logic [63:0] lo,
	input  logic [63:0] hi,
	output item_t       item
);

	logic [63:0] n;
	logic [63:0] m;
	logic [6:0]  bl;
	logic [2:0]  nb;

	always_comb begin
		n  = hi - lo;
		m  = n - 64'd1;
		bl = 7'd64 - clz64(m);
		nb = (word_bytes > 3'd4) ? 3'd4 : word_bytes;

		item.op        = op_t'(opcode);
		item.word      = word;
		item.nbits     = {nb, 3'b000};
		item.lo        = lo;
		item.range_err = (hi <= lo);
		item.m_clip    = (m > 64'd127) ? 7'd127 : m[6:0];
		item.m_big     = (m > 64'(MAX_RUN));
		item.hm1       = hi - 64'd1;
		item.mb_b      = bl;
		item.mb_big    = (bl != 7'd0) && ((bl - 7'd1) > 7'(MAX_RUN));
		item.mb_t      = (64'd1 << bl) - n;
		item.lo_mt     = lo - item.mb_t;
	end

endmodule

[sv/vlcbr_queue.sv]
module vlcbr_queue import vlcbr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output item_t rd_item,
	output logic  rd_valid
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

[sv/vlcbr_back.sv]
module vlcbr_back import vlcbr_pkg::*; #(
	parameter int BUFFER_BITS = 128,
	parameter int MAX_RUN     = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	output logic [1:0]  status,
	output logic [6:0]  bits_used,
	output logic [7:0]  bits_buffered
);

	localparam int FW = $clog2(BUFFER_BITS + 1);
	localparam int CW = FW + 2;
	localparam logic [CW-1:0] MAX_RUN_C = CW'(MAX_RUN);
	localparam logic [CW-1:0] BUF_C     = CW'(BUFFER_BITS);
	localparam logic [CW-1:0] GAMMA_LIM = CW'(32);

	logic [BUFFER_BITS-1:0] buf_q;
	logic [FW-1:0]          fill_q;
	logic                   out_valid_q;
	logic [63:0]            value_q;
	logic [1:0]             status_q;
	logic [6:0]             used_q;
	logic [7:0]             buffered_q;

	logic [63:0]            win;
	logic [6:0]             clz;
	logic [CW-1:0]          fill_c;
	logic [CW-1:0]          z_c;
	logic [6:0]             z;
	logic [4:0]             z5;
	st_t                    u_st;
	st_t                    g_st;
	logic [6:0]             g_len;
	logic [63:0]            g_grp;
	logic [31:0]            d_big;
	logic [7:0]             d_len;
	logic [63:0]            d_rest;
	logic [63:0]            d_sum;
	logic [6:0]             km1;
	logic [63:0]            mb_x;
	logic [63:0]            mb_x2;
	logic [31:0]            wmask;
	logic [BUFFER_BITS-1:0] pushed;

	st_t                    res_st;
	logic [63:0]            res_val;
	logic [6:0]             res_used;
	logic                   push_ok;
	logic [BUFFER_BITS-1:0] buf_n;
	logic [FW-1:0]          fill_n;

	assign pop = item_valid && (!out_valid_q || !out_stall);

	// shared decode front: leading-zero run, gamma prefix
	always_comb begin
		win    = buf_q[BUFFER_BITS-1 -: 64];
		clz    = clz64(win);
		fill_c = CW'(fill_q);
		z_c    = (CW'(clz) > fill_c) ? fill_c : CW'(clz);
		z      = z_c[6:0];
		z5     = z[4:0];

		if (z_c >= fill_c) begin
			u_st = (fill_c > MAX_RUN_C) ? ST_RANGE : ST_UNDER;
		end else if (z_c > MAX_RUN_C) begin
			u_st = ST_RANGE;
		end else begin
			u_st = ST_OK;
		end

		if (z_c >= fill_c) begin
			g_st = (fill_c > MAX_RUN_C || fill_c >= GAMMA_LIM) ? ST_RANGE : ST_UNDER;
		end else if (z_c > MAX_RUN_C || z_c >= GAMMA_LIM) begin
			g_st = ST_RANGE;
		end else if (fill_c < {z_c[CW-2:0], 1'b1}) begin
			g_st = ST_UNDER;
		end else begin
			g_st = ST_OK;
		end

		g_len  = {1'b0, z5, 1'b1};
		// the one bit and the z bits after it: 2^z + r
		g_grp  = (win << z5) >> (6'd63 - {1'b0, z5});
		d_big  = g_grp[31:0] - 32'd1;
		d_len  = {1'b0, g_len} + {2'b00, d_big[5:0]};
		d_rest = (win << g_len[5:0]) >> (7'd64 - {1'b0, d_big[5:0]});
		d_sum  = (64'd1 << d_big[5:0]) - 64'd1 + d_rest;

		km1    = item.mb_b - 7'd1;
		mb_x   = win >> (7'd64 - km1);
		mb_x2  = win >> (7'd64 - item.mb_b);

		wmask  = ~(32'hFFFF_FFFF >> item.nbits);
		pushed = {item.word & wmask, {(BUFFER_BITS-32){1'b0}}} >> fill_q;
	end

	always_comb begin
		res_st   = ST_OK;
		res_val  = '0;
		res_used = '0;
		push_ok  = 1'b0;
		unique case (item.op)
			OP_PUSH: begin
				if (fill_c + CW'(item.nbits) > BUF_C) begin
					res_st = ST_OVER;
				end else begin
					push_ok = 1'b1;
				end
			end
			OP_UNARY: begin
				res_st = u_st;
				res_val  = item.lo + 64'(z);
				res_used = z + 7'd1;
			end
			OP_BOUNDED: begin
				if (item.range_err) begin
					res_st = ST_RANGE;
				end else if (item.m_clip <= z) begin
					// run reached the limit, no terminator
					res_st   = item.m_big ? ST_RANGE : ST_OK;
					res_val  = item.hm1;
					res_used = item.m_clip;
				end else begin
					res_st   = u_st;
					res_val  = item.lo + 64'(z);
					res_used = z + 7'd1;
				end
			end
			OP_MINBIN: begin
				if (item.range_err) begin
					res_st = ST_RANGE;
				end else if (item.mb_b == 7'd0) begin
					res_val = item.lo;
				end else if (item.mb_big) begin
					res_st = ST_RANGE;
				end else if (fill_c < CW'(km1)) begin
					res_st = ST_UNDER;
				end else if (mb_x < item.mb_t) begin
					res_val  = item.lo + mb_x;
					res_used = km1;
				end else if (fill_c < CW'(item.mb_b)) begin
					res_st = ST_UNDER;
				end else begin
					res_val  = mb_x2 + item.lo_mt;
					res_used = item.mb_b;
				end
			end
			OP_GAMMA: begin
				res_st   = g_st;
				res_val  = {32'd0, item.lo[31:0] + g_grp[31:0] - 32'd1};
				res_used = g_len;
			end
			OP_DELTA: begin
				if (g_st != ST_OK) begin
					res_st = g_st;
				end else if (d_big > 32'(MAX_RUN) || d_len > 8'd64) begin
					res_st = ST_RANGE;
				end else if (fill_c < CW'(d_len)) begin
					res_st = ST_UNDER;
				end else begin
					res_val  = {32'd0, item.lo[31:0] + d_sum[31:0]};
					res_used = d_len[6:0];
				end
			end
			default: begin
				res_st = ST_RANGE;
			end
		endcase
		if (res_st != ST_OK || item.op == OP_PUSH) begin
			res_val  = '0;
			res_used = '0;
		end
	end

	always_comb begin
		if (push_ok) begin
			buf_n  = buf_q | pushed;
			fill_n = fill_q + FW'(item.nbits);
		end else begin
			buf_n  = buf_q << res_used;
			fill_n = fill_q - FW'(res_used);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				buf_q       <= buf_n;
				fill_q      <= fill_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q    <= res_val;
			status_q   <= res_st;
			used_q     <= res_used;
			buffered_q <= 8'(fill_n);
		end
	end

	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign status        = status_q;
	assign bits_used     = used_q;
	assign bits_buffered = buffered_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) <= BUF_C)
		else $error("bit fill beyond buffer size");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_q << fill_q) == '0)
		else $error("bits past fill not zero");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_st == ST_OK && item.op != OP_PUSH |-> CW'(res_used) <= fill_c)
		else $error("decode consumed more bits than held");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_st != ST_OK |=> $stable(fill_q))
		else $error("failed item changed the fill");

endmodule

[sv/variable_length_code_bit_reader_top.sv]
// Variable-length code bit reader. Words pushed with opcode 0 append their
// leading word_bytes bytes (big-endian, first byte first) to an MSB-first
// bit buffer of BUFFER_BITS bits; the other opcodes decode one code from the
// head of the buffer: unary, bounded unary over [lo, hi), minimal binary
// over [lo, hi), Elias gamma and Elias delta (the last two wrap to 32 bits).
// Every input word yields exactly one result word with value, status
// (ok, underflow, push overflow, range error), bits_used and bits_buffered.
// A failed decode or push leaves the buffer untouched, so after an underflow
// the caller pushes more data and retries. Throughput is one word per clock
// while the output is not stalled; output valid rises once an accepted word
// has passed the queue and the output register. The front stage classifies
// each word (range checks, minimal-binary widths and thresholds) and writes
// it into a two-entry queue; the back stage holds the buffer and decodes one
// word per clock unless stalled, its buffer update loop (leading zero count,
// window shift, add) setting the clock rate; it pauses while a result waits.
module variable_length_code_bit_reader_top import vlcbr_pkg::*; #(
	parameter int BUFFER_BITS = 128,
	parameter int MAX_RUN     = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] word,
	input  logic [2:0]  word_bytes,
	input  logic [63:0] lo,
	input  logic [63:0] hi,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	output logic [1:0]  status,
	output logic [6:0]  bits_used,
	output logic [7:0]  bits_buffered
);

	item_t front_item;
	item_t back_item;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;

	// front never holds a word; queue space is the only input stall
	assign in_stall = q_full;

	vlcbr_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.opcode    (opcode),
		.word      (word),
		.word_bytes(word_bytes),
		.lo        (lo),
		.hi        (hi),
		.item      (front_item)
	);

	vlcbr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (in_valid && !q_full),
		.wr_item (front_item),
		.full    (q_full),
		.rd      (q_pop),
		.rd_item (back_item),
		.rd_valid(q_valid)
	);

	// back: bit buffer, decode, output register
	vlcbr_back #(
		.BUFFER_BITS(BUFFER_BITS),
		.MAX_RUN    (MAX_RUN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (back_item),
		.item_valid   (q_valid),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.status       (status),
		.bits_used    (bits_used),
		.bits_buffered(bits_buffered)
	);

endmodule
